// ===== hdl/lru_wbc_pkg.sv =====
//------------------------------------------------------------------------------
// lru_wbc_pkg: shared types and constants
// Opcodes, actions, state encoding and the slot entry type of the cache
// controller.
//------------------------------------------------------------------------------
`default_nettype none
package lru_wbc_pkg;
	localparam int DefNumSlots = 32;
	localparam logic [31:0] DefFlushInterval = 32'd240;

	typedef enum logic [2:0] {
		OP_READ = 3'd0, OP_WRITE = 3'd1, OP_SYNC = 3'd2,
		OP_TICK = 3'd3, OP_INVAL = 3'd4, OP_STATS = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		ACT_HIT = 3'd0, ACT_FETCH = 3'd1, ACT_STORE = 3'd2,
		ACT_WB = 3'd3, ACT_DONE = 3'd4, ACT_REFUSED = 3'd5
	} action_t;

	localparam logic CFG_ENABLED = 1'b0;
	localparam logic CFG_FLUSH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_VICTIM_RD, ST_VICTIM, ST_UPDATE,
		ST_FLUSH, ST_FLUSH_LAST, ST_FLUSH_EMIT, ST_INVAL, ST_EMIT
	} state_t;

	// One memory word holds the whole slot.
	typedef struct packed {
		logic        valid;
		logic        dirty;
		logic [31:0] tag;
		logic [31:0] stamp;
	} slot_entry_t;
endpackage
`default_nettype wire

// ===== hdl/lru_writeback_block_cache_controller.sv =====
//------------------------------------------------------------------------------
// lru_writeback_block_cache_controller: tag and LRU policy controller
// Fully associative write-back sector cache controller with slot memory.
//------------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in channel (valid/stall); each is one transfer of
//   opcode, sector_address and request_end. Commands leave on the out channel
//   (out_valid/out_stall), one transfer per command, with last set on the
//   final command of a request and the four counters after the request.
//   The slot state lives in one synchronous RAM with a read and a write port,
//   read one entry a cycle. A read or write takes one pass over the slots, a
//   victim read, a victim check and an update step, then returns to idle, in
//   which the last command is taken. Sync and flushing ticks take one pass
//   over the slots, writebacks included, then emit their done command.
//   Invalidate sweeps the RAM once and then emits; other requests emit at once.
//   One request is worked on at a time; in_stall is high until its last
//   command has been taken. When the receiver stalls, the command register
//   holds its value and the sequencer waits.
//   After reset the RAM is swept once to clear it while in_stall stays high;
//   configuration writes are taken throughout.
//------------------------------------------------------------------------------
`default_nettype none
module lru_writeback_block_cache_controller
	import lru_wbc_pkg::*;
#(
	parameter int NUM_SLOTS = DefNumSlots
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [31:0] sector_address,
	input  wire logic        request_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       action,
	output logic [4:0]       slot,
	output logic [31:0]      disk_sector,
	output logic             end_of_request,
	output logic             last,
	output logic [31:0]      hit_count,
	output logic [31:0]      miss_count,
	output logic [31:0]      eviction_count,
	output logic [31:0]      writeback_count
);
	localparam int AW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);

	// Configuration registers.
	logic        enabled_q;
	logic [31:0] flush_interval_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			flush_interval_q <= DefFlushInterval;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ENABLED) enabled_q <= cfg_wdata[0];
			else flush_interval_q <= cfg_wdata;
		end
	end

	// Slot memory.
	slot_entry_t mem [NUM_SLOTS];
	logic        mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	slot_entry_t mem_wdata, rdata;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata <= mem[mem_raddr];
	end

	// Control and datapath registers.
	state_t state_q, state_d;
	logic [AW-1:0] addr_q, rd_idx_q, found_q, best_q, tgt_q;
	logic        found_v_q, inval_found_q;
	logic [31:0] best_stamp_q;
	logic [2:0]  op_q;
	logic [31:0] sec_q;
	logic        rend_q;
	logic [31:0] use_q, tick_q, hits_q, miss_q, evict_q, wb_q;
	logic [CW-1:0] dirty_cnt_q;
	logic        out_busy;
	logic        clr_q;

	assign out_busy = out_valid && out_stall;
	assign in_stall = (state_q != ST_IDLE) || clr_q || out_busy;
	wire in_acc = in_valid && !in_stall;

	// Address of the read issued this cycle.
	wire [AW-1:0] addr_inc = addr_q + AW'(1);
	wire addr_end = (addr_q == AW'(NUM_SLOTS - 1));

	// Scan bookkeeping for the entry returned this cycle.
	wire hit_now = rdata.valid && (rdata.tag == sec_q);
	wire inv_now = !rdata.valid;
	wire lower_now = rdata.stamp < best_stamp_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (opcode > OP_STATS || (opcode <= OP_SYNC && !enabled_q))
						state_d = ST_EMIT;
					else if (opcode == OP_READ || opcode == OP_WRITE)
						state_d = ST_SCAN;
					else if (opcode == OP_SYNC)
						state_d = ST_FLUSH;
					else if (opcode == OP_TICK && enabled_q &&
							(tick_q + 32'd1) >= flush_interval_q)
						state_d = ST_FLUSH;
					else if (opcode == OP_INVAL)
						state_d = ST_INVAL;
					else
						state_d = ST_EMIT;
				end
			end
			ST_SCAN: if (addr_end) state_d = ST_SCAN_LAST;
			ST_SCAN_LAST: state_d = ST_VICTIM_RD;
			ST_VICTIM_RD: state_d = ST_VICTIM;
			ST_VICTIM: if (!out_busy) state_d = ST_UPDATE;
			ST_UPDATE: if (!out_busy) state_d = ST_IDLE;
			ST_FLUSH: begin
				if (!out_busy) begin
					if (addr_end) state_d = ST_FLUSH_LAST;
				end
			end
			ST_FLUSH_LAST: if (!out_busy) state_d = ST_EMIT;
			ST_INVAL: if (addr_end) state_d = ST_EMIT;
			ST_EMIT: if (!out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Victim / hit choice at end of scan.
	wire [AW-1:0] fin_found = hit_now && !found_v_q ? rd_idx_q : found_q;
	wire fin_hit = found_v_q || hit_now;

	// A read hit keeps the dirty bit of its slot; a write always sets it.
	wire upd_dirty = (op_q == OP_WRITE) || (found_v_q && rdata.dirty);

	// Memory control.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_raddr = addr_q;
		case (state_q)
			ST_IDLE: mem_raddr = '0;
			ST_VICTIM_RD, ST_VICTIM: mem_raddr = tgt_q;
			ST_UPDATE: begin
				mem_raddr = tgt_q;
				mem_we = !out_busy;
				mem_waddr = tgt_q;
				mem_wdata.valid = 1'b1;
				mem_wdata.dirty = upd_dirty;
				mem_wdata.tag = sec_q;
				mem_wdata.stamp = use_q + 32'd1;
			end
			ST_FLUSH, ST_FLUSH_LAST: begin
				// Reread the pending entry while the output is stalled.
				mem_raddr = out_busy ? rd_idx_q : addr_q;
				// Clean the entry read last cycle if it was dirty.
				mem_we = !out_busy && rdata.dirty;
				mem_waddr = rd_idx_q;
				mem_wdata = rdata;
				mem_wdata.dirty = 1'b0;
			end
			ST_INVAL: begin
				mem_we = 1'b1;
			end
			default: ;
		endcase
		if (clr_q) begin
			mem_we = 1'b1;
			mem_waddr = addr_q;
			mem_wdata = '0;
		end
	end

	// A new command enters the output register this cycle.
	logic load_out;
	always_comb begin
		load_out = 1'b0;
		if (!out_busy) begin
			case (state_q)
				ST_VICTIM: load_out = !found_v_q && rdata.dirty;
				ST_UPDATE, ST_EMIT: load_out = 1'b1;
				ST_FLUSH, ST_FLUSH_LAST: load_out = rdata.dirty;
				default: load_out = 1'b0;
			endcase
		end
	end

	// Sequencer and datapath. rd_idx_q names the entry held in rdata during
	// a scan or a flush pass; the read of entry 0 is issued on acceptance.
	// dirty_cnt_q tracks the dirty slots so that a flush can count all of its
	// writebacks up front.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= 1'b1;
			addr_q <= '0;
			rd_idx_q <= '0;
			found_q <= '0;
			found_v_q <= 1'b0;
			inval_found_q <= 1'b0;
			best_q <= '0;
			best_stamp_q <= '1;
			tgt_q <= '0;
			use_q <= '0;
			tick_q <= '0;
			hits_q <= '0;
			miss_q <= '0;
			evict_q <= '0;
			wb_q <= '0;
			dirty_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (clr_q) begin
				if (addr_end) begin
					clr_q <= 1'b0;
					addr_q <= '0;
				end else begin
					addr_q <= addr_inc;
				end
			end else begin
				case (state_q)
					ST_IDLE: begin
						rd_idx_q <= '0;
						found_v_q <= 1'b0;
						inval_found_q <= 1'b0;
						best_q <= '0;
						best_stamp_q <= '1;
						if (in_acc && (opcode == OP_READ || opcode == OP_WRITE ||
								opcode == OP_SYNC || opcode == OP_TICK))
							addr_q <= AW'(1);
						else
							addr_q <= '0;
						if (in_acc) begin
							op_q <= opcode;
							sec_q <= sector_address;
							rend_q <= request_end;
							if (opcode == OP_TICK && enabled_q && opcode <= OP_STATS) begin
								if ((tick_q + 32'd1) >= flush_interval_q) tick_q <= '0;
								else tick_q <= tick_q + 32'd1;
							end
							if (opcode == OP_INVAL) use_q <= '0;
							// Every dirty slot is written back by a flush.
							if (state_d == ST_FLUSH) wb_q <= wb_q + 32'(dirty_cnt_q);
							if (state_d == ST_FLUSH || state_d == ST_INVAL) dirty_cnt_q <= '0;
						end
					end
					ST_SCAN, ST_SCAN_LAST: begin
						rd_idx_q <= addr_q;
						if (state_q == ST_SCAN) begin
							addr_q <= addr_inc;
							if (hit_now && !found_v_q) begin
								found_v_q <= 1'b1;
								found_q <= rd_idx_q;
							end
							if (!inval_found_q) begin
								if (inv_now) begin
									inval_found_q <= 1'b1;
									best_q <= rd_idx_q;
								end else if (lower_now) begin
									best_stamp_q <= rdata.stamp;
									best_q <= rd_idx_q;
								end
							end
						end else begin
							if (fin_hit) tgt_q <= fin_found;
							else if (!inval_found_q && inv_now) tgt_q <= rd_idx_q;
							else if (!inval_found_q && lower_now) tgt_q <= rd_idx_q;
							else tgt_q <= best_q;
							found_v_q <= fin_hit;
						end
					end
					ST_VICTIM: begin
						if (!out_busy && !found_v_q) begin
							if (op_q == OP_READ) miss_q <= miss_q + 32'd1;
							if (rdata.valid) evict_q <= evict_q + 32'd1;
							if (rdata.dirty) begin
								wb_q <= wb_q + 32'd1;
								action <= ACT_WB;
								slot <= 5'(tgt_q);
								disk_sector <= rdata.tag;
								end_of_request <= rend_q;
								last <= 1'b0;
							end
						end
					end
					ST_UPDATE: begin
						if (!out_busy) begin
							use_q <= use_q + 32'd1;
							slot <= 5'(tgt_q);
							disk_sector <= sec_q;
							end_of_request <= rend_q;
							last <= 1'b1;
							if (op_q == OP_WRITE) action <= ACT_STORE;
							else if (found_v_q) action <= ACT_HIT;
							else action <= ACT_FETCH;
							if (op_q == OP_READ && found_v_q) hits_q <= hits_q + 32'd1;
							if (upd_dirty && !rdata.dirty) dirty_cnt_q <= dirty_cnt_q + CW'(1);
							else if (!upd_dirty && rdata.dirty)
								dirty_cnt_q <= dirty_cnt_q - CW'(1);
						end
					end
					ST_FLUSH, ST_FLUSH_LAST: begin
						if (!out_busy) begin
							rd_idx_q <= addr_q;
							if (state_q == ST_FLUSH) addr_q <= addr_inc;
							if (rdata.dirty) begin
								action <= ACT_WB;
								slot <= 5'(rd_idx_q);
								disk_sector <= rdata.tag;
								end_of_request <= rend_q;
								last <= 1'b0;
							end
						end
					end
					ST_INVAL: addr_q <= addr_inc;
					ST_EMIT: begin
						if (!out_busy) begin
							action <= (op_q > OP_STATS || (op_q <= OP_SYNC && !enabled_q))
								? ACT_REFUSED : ACT_DONE;
							slot <= '0;
							disk_sector <= '0;
							end_of_request <= rend_q;
							last <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Counters shown with every command.
	assign hit_count = hits_q;
	assign miss_count = miss_q;
	assign eviction_count = evict_q;
	assign writeback_count = wb_q;
endmodule
`default_nettype wire

// ===== hdl/lru_wbc_checker.sv =====
//------------------------------------------------------------------------------
// lru_wbc_checker: port-level checks
// Watches the request and command channels of the cache controller.
//------------------------------------------------------------------------------
`default_nettype none
module lru_wbc_checker
	import lru_wbc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  action,
	input wire logic        last
);
	// A stalled command holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action))
		else $error("stalled command changed");
	// Done and refused always close a request.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_DONE || action == ACT_REFUSED) |-> last)
		else $error("done without last");
	// A writeback never closes a request.
	a_wb_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_WB |-> !last)
		else $error("writeback marked last");
	// Accepting a request stalls the input next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request accepted");
endmodule

bind lru_writeback_block_cache_controller lru_wbc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .action(action),
	.last(last)
);
`default_nettype wire

// ===== sim/tb_lru_writeback_block_cache_controller.sv =====
//------------------------------------------------------------------------------
// tb_lru_writeback_block_cache_controller: self-checking cache controller bench
// Sends sector requests, sync, ticks, invalidates, statistics and undefined opcodes
// under random idling on both channels. A behavioral copy of the tag and LRU policy
// predicts every command, which is compared field by field against the block's outputs.
//------------------------------------------------------------------------------
module tb_lru_writeback_block_cache_controller;
	import lru_wbc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Slots = 32;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	typedef struct {
		action_t     act;
		logic [4:0]  slot;
		logic [31:0] sector;
		logic        rend;
		logic        last;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evictions;
		logic [31:0] writebacks;
	} command_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] opcode = '0;
	logic [31:0] sector_address = '0;
	logic request_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] action;
	logic [4:0] slot;
	logic [31:0] disk_sector;
	logic end_of_request;
	logic last;
	logic [31:0] hit_count, miss_count, eviction_count, writeback_count;

	lru_writeback_block_cache_controller uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .sector_address(sector_address), .request_end(request_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .slot(slot), .disk_sector(disk_sector),
		.end_of_request(end_of_request), .last(last),
		.hit_count(hit_count), .miss_count(miss_count),
		.eviction_count(eviction_count), .writeback_count(writeback_count)
	);

	always #5 clk = ~clk;

	// Shadow copy of the cache state and configuration.
	logic        cache_on;
	logic [31:0] flush_period;
	logic        tag_valid [Slots];
	logic        tag_dirty [Slots];
	logic [31:0] tag_sector [Slots];
	logic [31:0] tag_stamp [Slots];
	logic [31:0] use_clock, tick_clock;
	logic [31:0] n_hits, n_misses, n_evictions, n_writebacks;

	command_t pending_cmds[$];
	command_t expected_cmds[$];
	int errors = 0;
	bit no_idle = 1'b0;
	logic [31:0] sector_pool [48];

	function automatic void add_cmd(action_t a, int s, logic [31:0] sec, logic rend);
		command_t c;
		c.act = a;
		c.slot = s[4:0];
		c.sector = sec;
		c.rend = rend;
		c.last = 1'b0;
		pending_cmds.push_back(c);
	endfunction

	function automatic void write_back_slot(int i, logic rend);
		add_cmd(ACT_WB, i, tag_sector[i], rend);
		tag_dirty[i] = 1'b0;
		n_writebacks++;
	endfunction

	function automatic void flush_dirty(logic rend);
		for (int i = 0; i < Slots; i++)
			if (tag_dirty[i]) write_back_slot(i, rend);
	endfunction

	function automatic int lookup(logic [31:0] sec);
		for (int i = 0; i < Slots; i++)
			if (tag_valid[i] && tag_sector[i] == sec) return i;
		return -1;
	endfunction

	// Victim: first invalid slot, else the first one with the lowest stamp.
	function automatic int allocate(logic [31:0] sec, logic rend);
		int v;
		logic [31:0] best;
		v = -1;
		best = 32'hFFFF_FFFF;
		for (int i = 0; i < Slots && v < 0; i++)
			if (!tag_valid[i]) v = i;
		if (v < 0) begin
			v = 0;
			for (int i = 0; i < Slots; i++)
				if (tag_stamp[i] < best) begin
					best = tag_stamp[i];
					v = i;
				end
		end
		if (tag_dirty[v]) begin
			write_back_slot(v, rend);
			n_evictions++;
		end else if (tag_valid[v]) begin
			n_evictions++;
		end
		tag_sector[v] = sec;
		return v;
	endfunction

	function automatic void clear_slots();
		for (int i = 0; i < Slots; i++) begin
			tag_valid[i] = 1'b0;
			tag_dirty[i] = 1'b0;
			tag_sector[i] = '0;
			tag_stamp[i] = '0;
		end
		use_clock = '0;
	endfunction

	// Works out the commands one request causes and queues them.
	function automatic void predict_commands(logic [2:0] op, logic [31:0] sec, logic rend);
		int i;
		command_t c;
		pending_cmds.delete();
		if (op > OP_STATS || (op <= OP_SYNC && !cache_on)) begin
			add_cmd(ACT_REFUSED, 0, '0, rend);
		end else begin
			case (op)
				OP_READ: begin
					i = lookup(sec);
					if (i >= 0) begin
						n_hits++;
						tag_stamp[i] = ++use_clock;
						add_cmd(ACT_HIT, i, sec, rend);
					end else begin
						n_misses++;
						i = allocate(sec, rend);
						add_cmd(ACT_FETCH, i, sec, rend);
						tag_valid[i] = 1'b1;
						tag_dirty[i] = 1'b0;
						tag_stamp[i] = ++use_clock;
					end
				end
				OP_WRITE: begin
					i = lookup(sec);
					if (i < 0) i = allocate(sec, rend);
					add_cmd(ACT_STORE, i, sec, rend);
					tag_valid[i] = 1'b1;
					tag_dirty[i] = 1'b1;
					tag_stamp[i] = ++use_clock;
				end
				OP_SYNC: begin
					flush_dirty(rend);
					add_cmd(ACT_DONE, 0, '0, rend);
				end
				OP_TICK: begin
					if (cache_on) begin
						tick_clock++;
						if (tick_clock >= flush_period) begin
							tick_clock = '0;
							flush_dirty(rend);
						end
					end
					add_cmd(ACT_DONE, 0, '0, rend);
				end
				OP_INVAL: begin
					clear_slots();
					add_cmd(ACT_DONE, 0, '0, rend);
				end
				default: add_cmd(ACT_DONE, 0, '0, rend);
			endcase
		end
		foreach (pending_cmds[k]) begin
			c = pending_cmds[k];
			c.last = (k == pending_cmds.size() - 1);
			c.hits = n_hits;
			c.misses = n_misses;
			c.evictions = n_evictions;
			c.writebacks = n_writebacks;
			expected_cmds.push_back(c);
		end
	endfunction

	// Sends one request; in_valid stays high afterward unless the next one idles.
	task automatic send_request(logic [2:0] op, logic [31:0] sec, logic rend);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		sector_address <= sec;
		request_end <= rend;
		do @(posedge clk); while (in_stall);
		predict_commands(op, sec, rend);
	endtask

	// Lets the block finish everything before a register write.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ENABLED) cache_on = data[0];
		else flush_period = data;
	endtask

	// Receiver: random stall per transfer, and field checks.
	int stall_left = 0;
	always @(posedge clk) begin
		command_t e;
		if (out_valid && !out_stall) begin
			if (expected_cmds.size() == 0) begin
				$error("unexpected command: action %0d slot %0d", action, slot);
				errors++;
			end else begin
				e = expected_cmds.pop_front();
				if (action !== e.act) begin
					$error("action: expected %0d, got %0d", e.act, action); errors++;
				end
				if (slot !== e.slot) begin
					$error("slot: expected %0d, got %0d", e.slot, slot); errors++;
				end
				if (disk_sector !== e.sector) begin
					$error("disk_sector: expected %h, got %h", e.sector, disk_sector);
					errors++;
				end
				if (end_of_request !== e.rend) begin
					$error("end_of_request: expected %b, got %b", e.rend, end_of_request);
					errors++;
				end
				if (last !== e.last) begin
					$error("last: expected %b, got %b", e.last, last); errors++;
				end
				if (hit_count !== e.hits) begin
					$error("hit_count: expected %0d, got %0d", e.hits, hit_count); errors++;
				end
				if (miss_count !== e.misses) begin
					$error("miss_count: expected %0d, got %0d", e.misses, miss_count);
					errors++;
				end
				if (eviction_count !== e.evictions) begin
					$error("eviction_count: expected %0d, got %0d", e.evictions,
						eviction_count);
					errors++;
				end
				if (writeback_count !== e.writebacks) begin
					$error("writeback_count: expected %0d, got %0d", e.writebacks,
						writeback_count);
					errors++;
				end
			end
			stall_left = no_idle ? 0 : $urandom_range(0, 13);
		end
		out_stall <= (stall_left > 0);
		if (stall_left > 0) stall_left--;
	end

	// With the cache off, only tick, invalidate and statistics are served.
	task automatic test_disabled();
		send_request(OP_READ, 32'h0000_0010, 1'b0);
		send_request(OP_WRITE, 32'h0000_0010, 1'b1);
		send_request(OP_SYNC, '0, 1'b0);
		send_request(OP_TICK, '0, 1'b1);
		send_request(OP_STATS, '0, 1'b0);
		send_request(OP_INVAL, '0, 1'b1);
		send_request(OP_SPARE6, 32'hFFFF_FFFF, 1'b0);
		send_request(OP_SPARE7, '0, 1'b1);
	endtask

	// Hits, misses, extreme sectors and a dirty eviction with the cache on.
	task automatic test_hit_miss();
		write_reg(CFG_ENABLED, 32'd1);
		write_reg(CFG_FLUSH, 32'hFFFF_FFFF);
		send_request(OP_WRITE, 32'h0000_0000, 1'b0);
		send_request(OP_WRITE, 32'hFFFF_FFFF, 1'b1);
		send_request(OP_READ, 32'hFFFF_FFFF, 1'b0);
		send_request(OP_READ, 32'h1234_5678, 1'b1);
		send_request(OP_WRITE, 32'h0000_0000, 1'b0);
		send_request(OP_SYNC, '0, 1'b1);
		send_request(OP_SYNC, '0, 1'b0);
		// Fill every slot, then miss so the least recent dirty slot is evicted.
		no_idle = 1'b1;
		for (int i = 0; i < Slots + 2; i++)
			send_request(i[0] ? OP_READ : OP_WRITE, 32'h100 + i, i[1]);
		no_idle = 1'b0;
		send_request(OP_READ, 32'h0000_0000, 1'b1);
		send_request(OP_SPARE7, '0, 1'b0);
		send_request(OP_STATS, '0, 1'b1);
	endtask

	// Automatic flush at the shortest and a short interval.
	task automatic test_tick_flush();
		write_reg(CFG_FLUSH, 32'd0);
		send_request(OP_WRITE, 32'h0000_0042, 1'b0);
		send_request(OP_TICK, '0, 1'b1);
		write_reg(CFG_FLUSH, 32'd2);
		send_request(OP_WRITE, 32'h0000_0043, 1'b0);
		send_request(OP_TICK, '0, 1'b0);
		send_request(OP_TICK, '0, 1'b1);
		send_request(OP_INVAL, '0, 1'b0);
	endtask

	task automatic send_random(int count);
		int r;
		logic [2:0] op;
		logic [31:0] sec;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 40) op = OP_READ;
			else if (r < 76) op = OP_WRITE;
			else if (r < 81) op = OP_SYNC;
			else if (r < 90) op = OP_TICK;
			else if (r < 93) op = OP_INVAL;
			else if (r < 96) op = OP_STATS;
			else op = r[0] ? OP_SPARE6 : OP_SPARE7;
			sec = ($urandom_range(0, 99) < 85) ? sector_pool[$urandom_range(0, 47)]
				: $urandom;
			send_request(op, sec, 1'($urandom_range(0, 1)));
		end
	endtask

	// Random traffic across several register settings.
	task automatic test_random();
		foreach (sector_pool[i]) sector_pool[i] = $urandom;
		sector_pool[0] = '0;
		sector_pool[1] = 32'hFFFF_FFFF;
		write_reg(CFG_FLUSH, 32'd5);
		send_random(120);
		// Hold off until every command is out, then run with no idling.
		drain();
		no_idle = 1'b1;
		send_random(60);
		no_idle = 1'b0;
		write_reg(CFG_FLUSH, 32'd1);
		send_random(80);
		write_reg(CFG_ENABLED, 32'd0);
		send_random(30);
		write_reg(CFG_ENABLED, 32'd1);
		write_reg(CFG_FLUSH, 32'hFFFF_FFFF);
		send_random(50);
	endtask

	initial begin
		cache_on = 1'b0;
		flush_period = DefFlushInterval;
		clear_slots();
		tick_clock = '0;
		n_hits = '0;
		n_misses = '0;
		n_evictions = '0;
		n_writebacks = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_disabled();
		test_hit_miss();
		test_tick_flush();
		test_random();
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_cmds.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
